[rtl/assert_macros.svh]
// Assertion macros for the RTL files; included by the FIFO top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clk edge, held off while rst_n is low.
`define BRB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clk edge, reset included.
`define BRB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/brb_pkg.sv]
// Constants and types of the byte ring buffer FIFO.
package brb_pkg;

    localparam int BUFFER_SIZE = 256;
    localparam int PTR_W       = $clog2(BUFFER_SIZE);
    localparam int DATA_W      = 8;
    localparam int OCC_W       = 8;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [DATA_W-1:0] byte_t;
    typedef logic [OCC_W-1:0]  occ_t;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Status of one word, carried from the access stage to the output stage.
    typedef struct packed {
        logic data_valid;
        logic push_accepted;
        logic oldest_dropped;
        occ_t occupancy;
    } status_t;

endpackage

[rtl/byte_ring_buffer_fifo.sv]
// Byte ring buffer FIFO: top level.
//
// Usage:
//   Input channel in_valid/in_stall carries one word: mode (0 push, 1 pop)
//   and data_in. Output channel out_valid/out_stall returns one result word
//   per input word: data_out, data_valid, push_accepted, oldest_dropped and
//   occupancy after the operation. A word moves when valid is high and
//   stall is low.
//   The buffer holds up to BUFFER_SIZE - 1 bytes. cfg_wr_en/cfg_wr_data set
//   overwrite_when_full (1 drops the oldest byte on a full push, 0 rejects).
//   Result path: the synchronous store read registers the popped byte, then
//   the output register holds the result word.
//   Throughput: one word per cycle while the receiver keeps out_stall low;
//   pointers update in the accept cycle and the single store port takes at most one
//   read or one write per word.
//   Reset clears both pointers (buffer empty), empties the pipeline and sets
//   overwrite_when_full to 1. Store contents are not cleared.
//   When the receiver stalls, the result holds in the output register, one
//   more word waits in the access stage, then in_stall rises.
module byte_ring_buffer_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  brb_pkg::byte_t       data_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output brb_pkg::byte_t       data_out,
    output logic                 data_valid,
    output logic                 push_accepted,
    output logic                 oldest_dropped,
    output brb_pkg::occ_t        occupancy
);
    import brb_pkg::*;

    `include "assert_macros.svh"

    byte_t   store_mem [BUFFER_SIZE];
    byte_t   rd_data_reg;

    ptr_t    wp_reg, wp_next;
    ptr_t    rp_reg, rp_next;
    logic    ovw_reg;

    logic    pend_valid_reg;
    status_t pend_reg;
    status_t pend_next;

    logic    out_valid_reg;
    status_t out_reg;
    byte_t   out_data_reg;

    logic    in_accept;
    logic    pend_move;
    logic    full;
    logic    empty;
    logic    do_write;
    logic    do_read;
    ptr_t    wp_inc;
    ptr_t    rp_inc;

    assign pend_move = pend_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = pend_valid_reg && !pend_move;
    assign in_accept = in_valid && !in_stall;

    assign wp_inc = wp_reg + ptr_t'(1);
    assign rp_inc = rp_reg + ptr_t'(1);
    assign full   = (wp_inc == rp_reg);
    assign empty  = (wp_reg == rp_reg);

    always_comb
    begin
        do_write  = 1'b0;
        do_read   = 1'b0;
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        pend_next = '0;
        if (mode == MODE_PUSH)
        begin
            if (!full || ovw_reg)
            begin
                do_write                = in_accept;
                wp_next                 = wp_inc;
                pend_next.push_accepted = 1'b1;
                if (full)
                begin
                    rp_next                  = rp_inc;
                    pend_next.oldest_dropped = 1'b1;
                end
            end
        end
        else if (!empty)
        begin
            do_read              = in_accept;
            rp_next              = rp_inc;
            pend_next.data_valid = 1'b1;
        end
        pend_next.occupancy = occ_t'(ptr_t'(wp_next - rp_next));
    end

    // Store: at most one write or one registered read per accepted word.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            store_mem[wp_reg] <= data_in;
        end
        if (do_read)
        begin
            rd_data_reg <= store_mem[rp_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            rp_reg         <= '0;
            ovw_reg        <= 1'b1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ovw_reg <= cfg_wr_data;
            end
            if (in_accept)
            begin
                wp_reg <= wp_next;
                rp_reg <= rp_next;
            end
            if (in_accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pend_reg <= pend_next;
        end
        if (pend_move)
        begin
            out_reg      <= pend_reg;
            out_data_reg <= pend_reg.data_valid ? rd_data_reg : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign data_out       = out_data_reg;
    assign data_valid     = out_reg.data_valid;
    assign push_accepted  = out_reg.push_accepted;
    assign oldest_dropped = out_reg.oldest_dropped;
    assign occupancy      = out_reg.occupancy;

    `BRB_ASSERT(a_pop_push_excl, out_valid |-> !(data_valid && push_accepted), "pop and push both flagged")
    `BRB_ASSERT(a_drop_needs_push, out_valid && oldest_dropped |-> push_accepted, "drop without push")
    `BRB_ASSERT(a_push_not_empty, in_accept && do_write |=> wp_reg != rp_reg, "empty after push")
    `BRB_ASSERT_ALWAYS(a_stall_needs_pend, in_stall |-> pend_valid_reg, "stall with empty stage")

endmodule
